// File: sv/rec_pkg.sv
package rec_pkg;

  // Field types
  typedef logic [1:0]        func_t;
  typedef logic [2:0]        btn_code_t;
  typedef logic signed [4:0] step_value_t;
  typedef logic [1:0]        cfg_index_t;
  typedef logic [2:0]        cfg_data_t;

  // Access codes
  localparam func_t FUNC_TICK       = 2'd0;
  localparam func_t FUNC_READ_VALUE = 2'd1;
  localparam func_t FUNC_READ_BTN   = 2'd2;

  // Button codes
  localparam btn_code_t BTN_OPEN     = 3'd0;
  localparam btn_code_t BTN_CLOSED   = 3'd1;
  localparam btn_code_t BTN_HELD     = 3'd2;
  localparam btn_code_t BTN_RELEASED = 3'd3;
  localparam btn_code_t BTN_CLICKED  = 3'd4;
  localparam btn_code_t BTN_DOUBLE   = 3'd5;

  // Register indexes
  localparam cfg_index_t REG_STEPS_PER_NOTCH = 2'd0;
  localparam cfg_index_t REG_ACCEL_ENABLE    = 2'd1;
  localparam cfg_index_t REG_DCLICK_ENABLE   = 2'd2;

  // Timing in ticks
  localparam int BUTTON_INTERVAL   = 10;
  localparam int DOUBLE_CLICK_TIME = 800;
  localparam int HOLD_TIME         = 500;
  localparam int HOLD_LIMIT        = HOLD_TIME / BUTTON_INTERVAL;
  localparam int DC_LIMIT          = DOUBLE_CLICK_TIME / BUTTON_INTERVAL;
  localparam logic [6:0] DC_LOAD   = (DC_LIMIT > 127) ? 7'd127 : 7'(DC_LIMIT);

  // Acceleration
  localparam logic [11:0] ACCEL_TOP       = 12'd3072;
  localparam logic [11:0] ACCEL_INC       = 12'd50;
  localparam logic [11:0] ACCEL_DEC       = 12'd2;
  localparam logic [11:0] ACCEL_RAISE_MAX = ACCEL_TOP - ACCEL_INC;

endpackage

// File: sv/rec_if.sv
// Encoder sample / access item
interface rec_sample_if import rec_pkg::*; ();
  logic  valid;
  logic  ready;
  func_t func;
  logic  pin_a;
  logic  pin_b;
  logic  pin_button;

  modport source (output valid, func, pin_a, pin_b, pin_button, input ready);
  modport sink   (input valid, func, pin_a, pin_b, pin_button, output ready);
endinterface

// Result item
interface rec_result_if import rec_pkg::*; ();
  logic        valid;
  logic        ready;
  step_value_t step_value;
  btn_code_t   button_code;

  modport source (output valid, step_value, button_code, input ready);
  modport sink   (input valid, step_value, button_code, output ready);
endinterface

// Register write channel
interface rec_cfg_if import rec_pkg::*; ();
  logic       valid;
  logic       ready;
  cfg_index_t index;
  cfg_data_t  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: sv/rotary_encoder_click_decoder.sv
// Rotary encoder decoder with acceleration and button click detection.
// Path: an accepted item goes through the input register, then the result
//   register, held there until taken; the state update is combinational.
// Throughput: one item per cycle while the result side takes results.
// Reset (synchronous, rst high): decoder state cleared, button open,
//   steps_per_notch = 1, acceleration and double click disabled.
module rotary_encoder_click_decoder import rec_pkg::*; (
  input logic         clk,
  input logic         rst,
  rec_sample_if.sink  sample,
  rec_result_if.source result,
  rec_cfg_if.sink     cfg
);

  // Configuration
  logic [2:0] steps_per_notch;
  logic       accel_enable;
  logic       dclick_enable;

  // Decoder state
  logic [1:0]  quad_phase, quad_phase_next;
  logic [15:0] step_count, step_count_next;
  logic [11:0] accel_level, accel_level_next;
  logic [3:0]  check_divider, check_divider_next;
  logic [7:0]  key_down_count, key_down_count_next;
  logic [6:0]  click_window, click_window_next;
  btn_code_t   button_status, button_status_next;

  // Input register
  logic  s1_valid;
  func_t s1_func;
  logic  s1_pa, s1_pb, s1_pbtn;

  // Result register
  logic        out_valid;
  step_value_t out_step, out_step_next;
  btn_code_t   out_code, out_code_next;

  // Work signals
  logic        advance;
  logic [1:0]  curr_phase, dphase;
  logic [3:0]  divider_inc;
  logic [15:0] step_rem;
  logic        step_nz;
  logic [4:0]  mag;

  assign advance      = !out_valid || result.ready;
  assign sample.ready = !s1_valid || advance;
  assign cfg.ready    = 1'b1;

  assign result.valid       = out_valid;
  assign result.step_value  = out_step;
  assign result.button_code = out_code;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      steps_per_notch <= 3'd1;
      accel_enable    <= 1'b0;
      dclick_enable   <= 1'b0;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_STEPS_PER_NOTCH: steps_per_notch <= cfg.data;
        REG_ACCEL_ENABLE:    accel_enable    <= cfg.data[0];
        REG_DCLICK_ENABLE:   dclick_enable   <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample.ready) begin
      s1_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      s1_func <= sample.func;
      s1_pa   <= sample.pin_a;
      s1_pb   <= sample.pin_b;
      s1_pbtn <= sample.pin_button;
    end
  end

  // Gray decode: active-low pins map to phase {~A, A^B}
  assign curr_phase  = {~s1_pa, s1_pa ^ s1_pb};
  assign dphase      = quad_phase - curr_phase;
  assign divider_inc = check_divider + 4'd1;

  // Remainder kept after a read, and whether a whole notch is pending
  always_comb begin
    unique case (steps_per_notch)
      3'd2: begin
        step_rem = {15'd0, step_count[0]};
        step_nz  = |step_count[15:1];
      end
      3'd4: begin
        step_rem = {14'd0, step_count[1:0]};
        step_nz  = |step_count[15:2];
      end
      default: begin
        step_rem = '0;
        step_nz  = |step_count;
      end
    endcase
  end

  assign mag = 5'd1 + (accel_enable ? {1'b0, accel_level[11:8]} : 5'd0);

  // Per-item state update and result
  always_comb begin
    quad_phase_next     = quad_phase;
    step_count_next     = step_count;
    accel_level_next    = accel_level;
    check_divider_next  = check_divider;
    key_down_count_next = key_down_count;
    click_window_next   = click_window;
    button_status_next  = button_status;
    out_step_next       = '0;
    out_code_next       = BTN_OPEN;

    unique case (s1_func)
      FUNC_TICK: begin
        if (accel_enable) begin
          accel_level_next = (accel_level >= ACCEL_DEC) ? accel_level - ACCEL_DEC : '0;
        end
        if (dphase[0]) begin
          quad_phase_next = curr_phase;
          step_count_next = dphase[1] ? step_count + 16'd1 : step_count - 16'd1;
        end
        if (accel_enable && dphase[0] && accel_level_next <= ACCEL_RAISE_MAX) begin
          accel_level_next = accel_level_next + ACCEL_INC;
        end

        // Button check every BUTTON_INTERVAL ticks
        check_divider_next = divider_inc;
        if (int'(divider_inc) >= BUTTON_INTERVAL) begin
          check_divider_next = '0;
          if (!s1_pbtn) begin
            button_status_next = BTN_CLOSED;
            if (key_down_count != 8'hFF) begin
              key_down_count_next = key_down_count + 8'd1;
            end
            if (int'(key_down_count_next) > HOLD_LIMIT) begin
              button_status_next = BTN_HELD;
            end
          end else begin
            if (key_down_count != 8'd0) begin
              priority if (button_status == BTN_HELD) begin
                button_status_next = BTN_RELEASED;
                click_window_next  = '0;
              end else if (click_window > 7'd1) begin
                if (int'(click_window) < DC_LIMIT) begin
                  button_status_next = BTN_DOUBLE;
                  click_window_next  = '0;
                end
              end else begin
                click_window_next = dclick_enable ? DC_LOAD : 7'd1;
              end
            end
            key_down_count_next = '0;
          end

          // Click window countdown, clicked when it runs out
          if (click_window_next != 7'd0) begin
            click_window_next = (click_window_next >= 7'd2) ? click_window_next - 7'd2 : '0;
            if (click_window_next == 7'd0) begin
              button_status_next = BTN_CLICKED;
            end
          end
        end
      end
      FUNC_READ_VALUE: begin
        step_count_next = step_rem;
        if (step_count[15]) begin
          out_step_next = 5'd0 - mag;
        end else if (step_nz) begin
          out_step_next = mag;
        end
      end
      FUNC_READ_BTN: begin
        out_code_next = button_status;
        if (button_status != BTN_HELD) begin
          button_status_next = BTN_OPEN;
        end
      end
      default: ;
    endcase
  end

  // State commit
  always_ff @(posedge clk) begin
    if (rst) begin
      quad_phase     <= '0;
      step_count     <= '0;
      accel_level    <= '0;
      check_divider  <= '0;
      key_down_count <= '0;
      click_window   <= '0;
      button_status  <= BTN_OPEN;
    end else if (s1_valid && advance) begin
      quad_phase     <= quad_phase_next;
      step_count     <= step_count_next;
      accel_level    <= accel_level_next;
      check_divider  <= check_divider_next;
      key_down_count <= key_down_count_next;
      click_window   <= click_window_next;
      button_status  <= button_status_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_valid && advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && advance) begin
      out_step <= out_step_next;
      out_code <= out_code_next;
    end
  end

  // Checks
  a_accel_top: assert property (@(posedge clk) disable iff (rst)
    accel_level <= ACCEL_TOP)
    else $error("acceleration level above top");

  a_divider_range: assert property (@(posedge clk) disable iff (rst)
    int'(check_divider) < BUTTON_INTERVAL)
    else $error("button check divider out of range");

  a_window_range: assert property (@(posedge clk) disable iff (rst)
    click_window <= DC_LOAD)
    else $error("click window above load value");

  a_btn_read_clears: assert property (@(posedge clk) disable iff (rst)
    s1_valid && advance && s1_func == FUNC_READ_BTN && button_status != BTN_HELD
    |=> button_status == BTN_OPEN)
    else $error("button read did not clear status");

  a_step_only_on_read: assert property (@(posedge clk) disable iff (rst)
    s1_valid && advance && s1_func != FUNC_READ_VALUE |=> out_step == 5'sd0)
    else $error("step value on non-read item");

endmodule

// File: test/tb_rotary_encoder_click_decoder.sv
module tb_rotary_encoder_click_decoder;
  import rec_pkg::*;

  // Codes the block must tolerate but never uses
  localparam func_t      FUNC_UNUSED = 2'd3;
  localparam cfg_index_t REG_UNUSED  = 2'd3;

  localparam int RESULT_LATENCY = 2;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 10;
  localparam int MAX_GAP        = 40;

  typedef struct packed {
    step_value_t step_value;
    btn_code_t   button_code;
  } readout_t;

  logic clk = 1'b0;
  logic rst;

  rec_sample_if smp ();
  rec_result_if res ();
  rec_cfg_if    cfg ();

  rotary_encoder_click_decoder u_top (
    .clk    (clk),
    .rst    (rst),
    .sample (smp),
    .result (res),
    .cfg    (cfg)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Idle rates and bookkeeping
  int snd_idle_pct;
  int rcv_idle_pct;
  int err_count = 0;
  int stall_cycles = 0;
  int items_sent;

  // Stimulus side: knob position being driven and button level (1 = open)
  logic [1:0] knob_pos;
  logic       btn_level;

  readout_t expected_readouts[$];

  // Predicted decoder state
  cfg_data_t   cfg_notch;
  logic        cfg_accel;
  logic        cfg_dclick;
  logic [1:0]  enc_phase;
  logic [15:0] enc_count;
  logic [11:0] accel_lvl;
  logic [3:0]  chk_div;
  logic [7:0]  key_down;
  logic [6:0]  click_win;
  btn_code_t   btn_state;

  function automatic void reset_decoder();
    cfg_notch  = 3'd1;
    cfg_accel  = 1'b0;
    cfg_dclick = 1'b0;
    enc_phase  = '0;
    enc_count  = '0;
    accel_lvl  = '0;
    chk_div    = '0;
    key_down   = '0;
    click_win  = '0;
    btn_state  = BTN_OPEN;
  endfunction

  function automatic void apply_reg(cfg_index_t idx, cfg_data_t val);
    case (idx)
      REG_STEPS_PER_NOTCH: cfg_notch = val;
      REG_ACCEL_ENABLE:    cfg_accel = val[0];
      REG_DCLICK_ENABLE:   cfg_dclick = val[0];
      default: ;
    endcase
  endfunction

  // Button state machine, run once per button interval
  function automatic void scan_button(logic pressed);
    if (pressed) begin
      btn_state = BTN_CLOSED;
      if (key_down != 8'd255) key_down = key_down + 8'd1;
      if (key_down > HOLD_LIMIT) btn_state = BTN_HELD;
    end else begin
      if (key_down != 8'd0) begin
        if (btn_state == BTN_HELD) begin
          btn_state = BTN_RELEASED;
          click_win = '0;
        end else if (click_win > 7'd1) begin
          if (click_win < DC_LIMIT) begin
            btn_state = BTN_DOUBLE;
            click_win = '0;
          end
        end else begin
          click_win = cfg_dclick ? DC_LOAD : 7'd1;
        end
      end
      key_down = '0;
    end
    // window countdown, clamped at zero; expiry means a plain click
    if (click_win != 7'd0) begin
      click_win = (click_win >= 7'd2) ? click_win - 7'd2 : 7'd0;
      if (click_win == 7'd0) btn_state = BTN_CLICKED;
    end
  endfunction

  function automatic void sample_tick(logic pa, logic pb, logic pbtn);
    logic [1:0] now_phase;
    logic [1:0] diff;
    logic       moved;
    moved = 1'b0;
    if (cfg_accel) accel_lvl = (accel_lvl >= ACCEL_DEC) ? accel_lvl - ACCEL_DEC : 12'd0;
    // Gray decode: a one-step change counts, a two-step jump is ignored
    now_phase = pa ? 2'd0 : 2'd3;
    if (!pb) now_phase = now_phase ^ 2'd1;
    diff = enc_phase - now_phase;
    if (diff[0]) begin
      enc_phase = now_phase;
      enc_count = diff[1] ? enc_count + 16'd1 : enc_count - 16'd1;
      moved = 1'b1;
    end
    if (cfg_accel && moved && accel_lvl <= ACCEL_RAISE_MAX) accel_lvl = accel_lvl + ACCEL_INC;
    chk_div = chk_div + 4'd1;
    if (chk_div >= BUTTON_INTERVAL) begin
      chk_div = '0;
      scan_button(!pbtn);
    end
  endfunction

  // Movement since last read; the part below one notch is kept
  function automatic step_value_t take_movement();
    logic [15:0] cnt;
    logic [1:0]  shamt;
    logic [4:0]  mag;
    cnt = enc_count;
    shamt = 2'd0;
    case (cfg_notch)
      3'd2: begin
        enc_count = {15'd0, cnt[0]};
        shamt = 2'd1;
      end
      3'd4: begin
        enc_count = {14'd0, cnt[1:0]};
        shamt = 2'd2;
      end
      default: enc_count = '0;
    endcase
    mag = 5'd1 + (cfg_accel ? {1'b0, accel_lvl[11:8]} : 5'd0);
    if (cnt[15]) return 5'd0 - mag;
    if ((cnt >> shamt) != 16'd0) return mag;
    return '0;
  endfunction

  function automatic readout_t decode_access(func_t f, logic pa, logic pb, logic pbtn);
    readout_t r;
    r = '0;
    case (f)
      FUNC_TICK:       sample_tick(pa, pb, pbtn);
      FUNC_READ_VALUE: r.step_value = take_movement();
      FUNC_READ_BTN: begin
        r.button_code = btn_state;
        if (btn_state != BTN_HELD) btn_state = BTN_OPEN;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Track accepted items and writes, check every result against the oldest prediction
  always @(posedge clk) begin : check_results
    readout_t want;
    if (rst) begin
      reset_decoder();
    end else begin
      if (cfg.valid && cfg.ready) apply_reg(cfg.index, cfg.data);
      if (smp.valid && smp.ready)
        expected_readouts.push_back(decode_access(smp.func, smp.pin_a, smp.pin_b,
                                                  smp.pin_button));
      if (res.valid && res.ready) begin
        if (expected_readouts.size() == 0) begin
          if (err_count < MAX_REPORTS)
            $display("%0t: result with nothing pending: step_value %0d button_code %0d",
                     $realtime, res.step_value, res.button_code);
          err_count++;
        end else begin
          want = expected_readouts.pop_front();
          if (res.step_value !== want.step_value || res.button_code !== want.button_code) begin
            if (err_count < MAX_REPORTS)
              $display("%0t: mismatch: step_value exp %0d got %0d, button_code exp %0d got %0d",
                       $realtime, want.step_value, res.step_value, want.button_code,
                       res.button_code);
            err_count++;
          end
        end
      end
    end
  end

  // Result back-pressure
  always @(posedge clk) res.ready <= ($urandom_range(99) >= rcv_idle_pct);

  // Watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (rst || (smp.valid && smp.ready) || (res.valid && res.ready) ||
        (cfg.valid && cfg.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d results pending", $realtime,
               expected_readouts.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Send one item, with a random gap before it
  task automatic send_item(func_t f, logic pa, logic pb, logic pbtn);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < snd_idle_pct) gap++;
    if (gap > 0) begin
      smp.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    smp.valid      <= 1'b1;
    smp.func       <= f;
    smp.pin_a      <= pa;
    smp.pin_b      <= pb;
    smp.pin_button <= pbtn;
    @(posedge clk);
    while (!smp.ready) @(posedge clk);
    items_sent++;
  endtask

  // Hold off until every predicted result has come out
  task automatic wait_results_done();
    smp.valid <= 1'b0;
    @(posedge clk);
    while (expected_readouts.size() != 0) @(posedge clk);
    repeat (RESULT_LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, cfg_data_t val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Single-bit registers get random upper data bits
  task automatic set_config(cfg_data_t notch, logic accel, logic dclick);
    wait_results_done();
    write_reg(REG_STEPS_PER_NOTCH, notch);
    write_reg(REG_ACCEL_ENABLE, {2'($urandom_range(3)), accel});
    write_reg(REG_DCLICK_ENABLE, {2'($urandom_range(3)), dclick});
  endtask

  // Pins for the current knob position: A = ~p[1], B = ~(p[1] ^ p[0])
  task automatic tick_item();
    send_item(FUNC_TICK, ~knob_pos[1], ~(knob_pos[1] ^ knob_pos[0]), btn_level);
  endtask

  task automatic turn_knob(int steps, bit up);
    repeat (steps) begin
      knob_pos = up ? knob_pos + 2'd1 : knob_pos - 2'd1;
      tick_item();
    end
  endtask

  // Ticks at the current button level, knob moving now and then
  task automatic dwell(int ticks, int move_pct);
    repeat (ticks) begin
      if ($urandom_range(99) < move_pct)
        knob_pos = $urandom_range(1) ? knob_pos + 2'd1 : knob_pos - 2'd1;
      tick_item();
    end
  endtask

  task automatic read_knob();
    send_item(FUNC_READ_VALUE, 1'($urandom_range(1)), 1'($urandom_range(1)),
              1'($urandom_range(1)));
  endtask

  task automatic read_button();
    send_item(FUNC_READ_BTN, 1'($urandom_range(1)), 1'($urandom_range(1)),
              1'($urandom_range(1)));
  endtask

  task automatic test_access_basics();
    read_knob();
    read_button();
    send_item(FUNC_UNUSED, 1'b0, 1'b0, 1'b0);
    send_item(FUNC_UNUSED, 1'b1, 1'b1, 1'b1);
    tick_item();
    // one full cycle up, then one step down
    turn_knob(4, 1'b1);
    read_knob();
    turn_knob(1, 1'b0);
    read_knob();
    // two-step jump is not a move
    knob_pos = knob_pos + 2'd2;
    tick_item();
    read_knob();
    turn_knob(2, 1'b0);
    read_knob();
    read_knob();
  endtask

  task automatic test_single_click();
    btn_level = 1'b0;
    dwell(10, 0);
    read_button();
    btn_level = 1'b1;
    dwell(10, 0);
    read_button();
    read_button();
  endtask

  task automatic test_double_click();
    // press, release, press again inside the window
    btn_level = 1'b0;
    dwell(10, 0);
    btn_level = 1'b1;
    dwell(10, 0);
    btn_level = 1'b0;
    dwell(10, 0);
    btn_level = 1'b1;
    dwell(10, 0);
    read_button();
    read_button();
  endtask

  task automatic test_notch_values();
    for (int v = 0; v < 8; v++) begin
      wait_results_done();
      write_reg(REG_STEPS_PER_NOTCH, cfg_data_t'(v));
      turn_knob($urandom_range(1, 6), 1'($urandom_range(1)));
      read_knob();
      turn_knob(3, 1'($urandom_range(1)));
      read_knob();
    end
    wait_results_done();
    write_reg(REG_UNUSED, cfg_data_t'($urandom_range(7)));
  endtask

  task automatic test_random_gestures(int n_items);
    int start_count;
    int pick;
    func_t nf;
    logic na;
    logic nb;
    start_count = items_sent;
    while (items_sent - start_count < n_items) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        turn_knob($urandom_range(1, 12), 1'($urandom_range(1)));
        // contact bounce: a step back and forth
        if ($urandom_range(3) == 0) begin
          turn_knob(1, 1'b0);
          turn_knob(1, 1'b1);
        end
      end else if (pick < 55) begin
        read_knob();
      end else if (pick < 65) begin
        read_button();
      end else if (pick < 77) begin
        btn_level = 1'b0;
        dwell($urandom_range(8, 30), 20);
        btn_level = 1'b1;
        dwell($urandom_range(10, 20), 20);
        read_button();
      end else if (pick < 82) begin
        btn_level = 1'b0;
        dwell($urandom_range(10, 25), 10);
        btn_level = 1'b1;
        if ($urandom_range(5) == 0) dwell($urandom_range(300, 420), 10);
        else dwell($urandom_range(10, 100), 10);
        btn_level = 1'b0;
        dwell($urandom_range(10, 25), 10);
        btn_level = 1'b1;
        dwell($urandom_range(10, 20), 10);
        read_button();
      end else if (pick < 90) begin
        dwell($urandom_range(1, 30), 0);
      end else if (pick < 98) begin
        // raw item with random fields; resync the knob if it was a tick
        nf = func_t'($urandom_range(3));
        na = 1'($urandom_range(1));
        nb = 1'($urandom_range(1));
        send_item(nf, na, nb, 1'($urandom_range(1)));
        if (nf == FUNC_TICK) knob_pos = {~na, na ^ nb};
      end else begin
        wait_results_done();
      end
    end
    btn_level = 1'b1;
  endtask

  // Held past the hold threshold while the knob spins at full acceleration,
  // then released; acceleration has decayed a little by the last read
  task automatic test_long_press();
    btn_level = 1'b0;
    for (int i = 0; i < 3; i++) begin
      turn_knob(172, i != 1);
      read_knob();
      read_button();
    end
    btn_level = 1'b1;
    dwell(10, 0);
    read_knob();
    turn_knob(1, 1'b0);
    read_knob();
    read_button();
    read_button();
  endtask

  initial begin
    rst            <= 1'b1;
    smp.valid      <= 1'b0;
    smp.func       <= FUNC_TICK;
    smp.pin_a      <= 1'b1;
    smp.pin_b      <= 1'b1;
    smp.pin_button <= 1'b1;
    cfg.valid      <= 1'b0;
    cfg.index      <= REG_STEPS_PER_NOTCH;
    cfg.data       <= '0;
    snd_idle_pct = 11;
    rcv_idle_pct = 87;
    items_sent   = 0;
    knob_pos     = 2'd0;
    btn_level    = 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Sender rarely idle, receiver mostly stalled
    test_access_basics();
    test_single_click();
    set_config(3'd2, 1'b1, 1'b1);
    test_double_click();
    test_random_gestures(50);

    // Sender mostly idle, receiver rarely stalled
    wait_results_done();
    snd_idle_pct = 87;
    rcv_idle_pct = 11;
    test_notch_values();
    set_config(3'd4, 1'b1, 1'b0);
    test_random_gestures(50);

    // Full rate both ways
    wait_results_done();
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    set_config(3'd7, 1'b0, 1'b1);
    test_random_gestures(50);
    set_config(3'd1, 1'b1, 1'b0);
    test_long_press();

    wait_results_done();
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
